>>> rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Shared widths, command and register codes, and the result record that the
// controller hands to the output stage.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DEPTH_DEFAULT = 256;

  localparam int DATA_W     = 8;
  localparam int CMD_W      = 3;
  localparam int QTY_W      = 9;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_WRITE  = 3'd0;
  localparam cmd_t CMD_READ   = 3'd1;
  localparam cmd_t CMD_PEEK   = 3'd2;
  localparam cmd_t CMD_REWIND = 3'd3;
  localparam cmd_t CMD_CLEAR  = 3'd4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BUFFER_SIZE    = 2'd0;
  localparam cfg_idx_t CFG_ALLOW_OVERFLOW = 2'd1;

  typedef struct packed {
    logic [DATA_W-1:0] rd_data;
    logic              accepted;
    logic              read_error;
    logic              overflow_fault;
    logic              buffer_fault;
    logic [CNT_W-1:0]  readable_count;
  } result_t;

endpackage

>>> rtl/brb_mem.sv
// ----------------------------------------------------------------------------
// Byte ring buffer store
// Synchronous byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module brb_mem #(
  parameter int DEPTH = brb_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [brb_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [brb_pkg::DATA_W-1:0] rdata
);
  import brb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/brb_ctrl.sv
// ----------------------------------------------------------------------------
// Byte ring buffer controller
// Holds the pointers and fault flags, sequences each command against the
// store, runs the zeroing sweep and forms the result record.
// ----------------------------------------------------------------------------
module brb_ctrl #(
  parameter int DEPTH = brb_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int SW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [brb_pkg::CMD_W-1:0]   cmd,
  input  logic [brb_pkg::DATA_W-1:0]  wr_data,
  input  logic [brb_pkg::QTY_W-1:0]   rewind_count,
  input  logic [SW-1:0]               sz,
  input  logic                        allow_overflow,
  input  logic                        size_wr,
  input  logic                        out_busy,
  output logic                        res_valid,
  output brb_pkg::result_t            res,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [brb_pkg::DATA_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [brb_pkg::DATA_W-1:0]  mem_rdata
);
  import brb_pkg::*;

  localparam int RW = ((SW > QTY_W) ? SW : QTY_W) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_SWEEP = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] data_q;
  logic [QTY_W-1:0]  qty_q;
  logic [AW-1:0]     wp, wp_next;
  logic [AW-1:0]     rp, rp_next;
  logic              ovf, ovf_next;
  logic              cor, cor_next;
  logic [AW-1:0]     sweep_addr;
  logic              reply, reply_next;
  logic              accept;

  logic [SW-1:0]     rp_inc, wp_inc;
  logic [AW-1:0]     rp_adv, wp_adv;
  logic              full, empty;

  logic [RW-1:0]     rw_q, rw_r, rw_s, rw_diff;
  logic [RW-1:0]     cnt_t, cnt_m;

  assign rp_inc = SW'(rp) + SW'(1);
  assign wp_inc = SW'(wp) + SW'(1);
  assign rp_adv = (rp_inc >= sz) ? '0 : rp_inc[AW-1:0];
  assign wp_adv = (wp_inc >= sz) ? '0 : wp_inc[AW-1:0];
  assign full   = (wp == rp);
  assign empty  = (rp_adv == wp);

  // Rewind: move back modulo the ring size, or fault when too far.
  assign rw_q    = RW'(qty_q);
  assign rw_r    = RW'(rp);
  assign rw_s    = RW'(sz);
  assign rw_diff = rw_r - rw_q;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    reply_next = reply;
    wp_next    = wp;
    rp_next    = rp;
    ovf_next   = ovf;
    cor_next   = cor;
    mem_we     = 1'b0;
    mem_waddr  = sweep_addr;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = rp_adv;
    res_valid  = 1'b0;
    res        = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          mem_re = (cmd == CMD_READ) || (cmd == CMD_PEEK);
          if (cmd == CMD_CLEAR) begin
            state_next = ST_SWEEP;
            reply_next = 1'b1;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (!out_busy) begin
          res_valid  = 1'b1;
          state_next = ST_IDLE;
          case (cmd_q)
            CMD_WRITE: begin
              if (!ovf && !cor) begin
                if (full) begin
                  if (!allow_overflow) begin
                    ovf_next = 1'b1;
                  end
                end else begin
                  mem_we       = 1'b1;
                  mem_waddr    = wp;
                  mem_wdata    = data_q;
                  wp_next      = wp_adv;
                  res.accepted = 1'b1;
                end
              end
            end
            CMD_READ, CMD_PEEK: begin
              if (cor || empty) begin
                res.read_error = 1'b1;
              end else begin
                res.rd_data  = mem_rdata;
                res.accepted = 1'b1;
                if (cmd_q == CMD_READ) begin
                  mem_we    = 1'b1;
                  mem_waddr = rp_adv;
                  rp_next   = rp_adv;
                end
              end
            end
            CMD_REWIND: begin
              if (rw_q <= rw_r) begin
                rp_next = rw_diff[AW-1:0];
              end else if (rw_q <= rw_r + rw_s) begin
                rp_next = AW'(rw_diff + rw_s);
              end else begin
                cor_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
          res.overflow_fault = ovf_next;
          res.buffer_fault   = cor_next;
        end
      end
      ST_SWEEP: begin
        mem_we = 1'b1;
        if (sweep_addr == LAST_ADDR) begin
          wp_next    = '0;
          rp_next    = AW'(sz - SW'(1));
          ovf_next   = 1'b0;
          cor_next   = 1'b0;
          reply_next = 1'b0;
          state_next = reply ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase

    if (size_wr) begin
      state_next = ST_SWEEP;
    end

    // Readable count from the pointers after the command.
    cnt_t = RW'(wp_next) + rw_s - RW'(rp_next) - RW'(1);
    cnt_m = (cnt_t >= rw_s) ? (cnt_t - rw_s) : cnt_t;
    if (res_valid) begin
      res.readable_count = cnt_m[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      reply      <= 1'b0;
      sweep_addr <= '0;
      ovf        <= 1'b0;
      cor        <= 1'b0;
      wp         <= '0;
      rp         <= '0;
    end else begin
      state <= state_next;
      reply <= reply_next;
      ovf   <= ovf_next;
      cor   <= cor_next;
      wp    <= wp_next;
      rp    <= rp_next;
      if ((state == ST_SWEEP) && (sweep_addr != LAST_ADDR)) begin
        sweep_addr <= sweep_addr + AW'(1);
      end else begin
        sweep_addr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      data_q <= wr_data;
      qty_q  <= rewind_count;
    end
  end

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ((SW'(wp) < sz) && (SW'(rp) < sz)))
    else $error("ring pointer outside the active size");

  a_res_free: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !out_busy)
    else $error("result offered while the output register is held");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SWEEP) && (sweep_addr == LAST_ADDR) && !reply && !size_wr)
      |=> ((state == ST_IDLE) && (wp == '0) && !ovf && !cor))
    else $error("sweep did not leave an empty, fault-free ring");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("store written while idle");
`endif

endmodule

>>> rtl/byte_ring_buffer_with_faults.sv
// ----------------------------------------------------------------------------
// Byte ring buffer with faults
// Circular byte FIFO with write, read, peek, rewind and clear commands and sticky
// overflow and buffer faults; one result item for every command item.
// ----------------------------------------------------------------------------
// A command item is taken in the idle state, which issues the store read,
// and finished in the execute state, which returns the byte, writes the
// store back and loads the output register once it is free; the store has
// a registered read port. A clear command, and any write of the buffer_size
// register, starts a zeroing sweep of the whole store that writes one slot
// a cycle; the clear result item is offered from the execute state that
// follows the sweep. After reset the same sweep runs before the first command
// item is taken. Configuration writes are always taken, but should only be
// made while the block is idle. The output register lets a command be taken
// while the previous result item is still waiting on out_stall.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_faults #(
  parameter int DEPTH = brb_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [brb_pkg::CMD_W-1:0]     cmd,
  input  logic [brb_pkg::DATA_W-1:0]    wr_data,
  input  logic [brb_pkg::QTY_W-1:0]     rewind_count,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brb_pkg::DATA_W-1:0]    rd_data,
  output logic                          accepted,
  output logic                          read_error,
  output logic                          overflow_fault,
  output logic                          buffer_fault,
  output logic [brb_pkg::CNT_W-1:0]     readable_count,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [brb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import brb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = (SW > CFG_DATA_W) ? SW : CFG_DATA_W;
  localparam logic [SW-1:0] SZ_RESET = SW'((DEPTH < 256) ? DEPTH : 256);

  logic [SW-1:0]     sz;
  logic              allow_ovf;
  logic              cfg_wr;
  logic              size_wr;
  logic [CW-1:0]     bs_ext;
  logic [SW-1:0]     sz_new;
  logic              out_busy;
  logic              res_valid;
  result_t           res;
  result_t           res_q;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign size_wr   = cfg_wr && (cfg_index == CFG_BUFFER_SIZE);

  // The ring size saturates to the range two to DEPTH, so that the pointers
  // always index a slot that exists.
  assign bs_ext = CW'(cfg_data);
  always_comb begin
    if (bs_ext < CW'(2)) begin
      sz_new = SW'(2);
    end else if (bs_ext > CW'(DEPTH)) begin
      sz_new = SW'(DEPTH);
    end else begin
      sz_new = bs_ext[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sz        <= SZ_RESET;
      allow_ovf <= 1'b0;
    end else begin
      if (size_wr) begin
        sz <= sz_new;
      end
      if (cfg_wr && (cfg_index == CFG_ALLOW_OVERFLOW)) begin
        allow_ovf <= cfg_data[0];
      end
    end
  end

  // Output register: the controller only offers a result when it is free or
  // being emptied in this cycle.
  assign out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign rd_data        = res_q.rd_data;
  assign accepted       = res_q.accepted;
  assign read_error     = res_q.read_error;
  assign overflow_fault = res_q.overflow_fault;
  assign buffer_fault   = res_q.buffer_fault;
  assign readable_count = res_q.readable_count;

  brb_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .SW    (SW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .wr_data        (wr_data),
    .rewind_count   (rewind_count),
    .sz             (sz),
    .allow_overflow (allow_ovf),
    .size_wr        (size_wr),
    .out_busy       (out_busy),
    .res_valid      (res_valid),
    .res            (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  brb_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Byte ring buffer with faults: self-checking testbench
// Drives command items into the ring buffer and checks every result item
// against a behavioural model of the ring that the testbench keeps itself.
// Directed tests cover the commands, both faults and the size limits. Random
// traffic under several patterns of sender gaps and receiver stalls follows.
// ----------------------------------------------------------------------------
module testbench;

  import brb_pkg::*;

  localparam int RING_DEPTH  = DEPTH_DEFAULT;
  localparam int LIMIT_CYCLES = 400000;
  localparam int REPORT_MAX  = 10;

  // Command codes that the block treats as no operation.
  localparam cmd_t CMD_UNUSED_LO = 3'd5;
  localparam cmd_t CMD_UNUSED_HI = 3'd7;

  // Register index that selects no register at all.
  localparam cfg_idx_t CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst;

  logic                  in_valid;
  logic                  in_stall;
  cmd_t                  cmd;
  logic [DATA_W-1:0]     wr_data;
  logic [QTY_W-1:0]      rewind_count;
  logic                  out_valid;
  logic                  out_stall;
  logic [DATA_W-1:0]     rd_data;
  logic                  accepted;
  logic                  read_error;
  logic                  overflow_fault;
  logic                  buffer_fault;
  logic [CNT_W-1:0]      readable_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  byte_ring_buffer_with_faults uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .wr_data        (wr_data),
    .rewind_count   (rewind_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .rd_data        (rd_data),
    .accepted       (accepted),
    .read_error     (read_error),
    .overflow_fault (overflow_fault),
    .buffer_fault   (buffer_fault),
    .readable_count (readable_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // The clock period is 20 time units, low half first.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the ring. It is updated at the clock edge at which a command
  // item or a register write is taken, so it always mirrors what the block
  // ought to hold once that item has been processed.
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] ring_bytes [RING_DEPTH];
  int unsigned       ring_wr;
  int unsigned       ring_rd;
  logic              ovf_flag;
  logic              fault_flag;
  logic [8:0]        size_reg;
  logic              allow_ovf;

  result_t pending_status [$];
  int      fail_count;
  int      cycle_count;
  int      idle_pct;
  int      stall_pct;

  // The register value is saturated to the sizes that the store can hold.
  function automatic int unsigned ring_size();
    int unsigned s;
    s = size_reg;
    if (s < 2) s = 2;
    if (s > RING_DEPTH) s = RING_DEPTH;
    return s;
  endfunction

  function automatic int unsigned ring_next(int unsigned p);
    return (p + 1 >= ring_size()) ? 0 : p + 1;
  endfunction

  function automatic void clear_ring();
    foreach (ring_bytes[i]) ring_bytes[i] = '0;
    ring_rd    = ring_size() - 1;
    ring_wr    = 0;
    ovf_flag   = 1'b0;
    fault_flag = 1'b0;
  endfunction

  function automatic void apply_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_BUFFER_SIZE: begin
        // A new size always starts from an empty ring.
        size_reg = val;
        clear_ring();
      end
      CFG_ALLOW_OVERFLOW: begin
        allow_ovf = val[0];
      end
      default: begin
      end
    endcase
  endfunction

  // Works out the status that one command item should report, and moves the
  // ring on as the command demands.
  function automatic result_t apply_command(cmd_t op, logic [DATA_W-1:0] data,
                                            logic [QTY_W-1:0] qty);
    result_t     r;
    int unsigned sz;
    int unsigned nxt;
    sz = ring_size();
    r  = '0;
    case (op)
      CMD_WRITE: begin
        // Either sticky fault refuses the write and leaves everything as it is.
        if (!ovf_flag && !fault_flag) begin
          if (ring_wr == ring_rd) begin
            if (!allow_ovf) ovf_flag = 1'b1;
          end else begin
            ring_bytes[ring_wr] = data;
            ring_wr = ring_next(ring_wr);
            r.accepted = 1'b1;
          end
        end
      end
      CMD_READ, CMD_PEEK: begin
        nxt = ring_next(ring_rd);
        if (fault_flag || nxt == ring_wr) begin
          r.read_error = 1'b1;
        end else begin
          r.rd_data  = ring_bytes[nxt];
          r.accepted = 1'b1;
          if (op == CMD_READ) begin
            ring_bytes[nxt] = '0;
            ring_rd = nxt;
          end
        end
      end
      CMD_REWIND: begin
        // A rewind beyond one full wrap corrupts the ring instead of moving.
        if (qty <= ring_rd) begin
          ring_rd = ring_rd - qty;
        end else if (qty - ring_rd <= sz) begin
          ring_rd = ring_rd + sz - qty;
        end else begin
          fault_flag = 1'b1;
        end
      end
      CMD_CLEAR: begin
        clear_ring();
      end
      default: begin
      end
    endcase
    r.overflow_fault = ovf_flag;
    r.buffer_fault   = fault_flag;
    r.readable_count = CNT_W'((ring_wr + 2 * sz - ring_rd - 1) % sz);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor. Outputs are sampled at the rising edge. A result item is checked
  // before a command item of the same edge is modelled; each result is still
  // registered after its command is taken, so the two never belong together.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{rd_data, accepted, read_error, overflow_fault, buffer_fault,
                readable_count};
        if (pending_status.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result item: rd_data %02h accepted %0b err %0b ovf %0b flt %0b count %0d",
                     got.rd_data, got.accepted, got.read_error, got.overflow_fault,
                     got.buffer_fault, got.readable_count);
        end else begin
          want = pending_status.pop_front();
          if (got.rd_data !== want.rd_data || got.accepted !== want.accepted ||
              got.read_error !== want.read_error ||
              got.overflow_fault !== want.overflow_fault ||
              got.buffer_fault !== want.buffer_fault ||
              got.readable_count !== want.readable_count) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("mismatch at cycle %0d", cycle_count);
              $display("  expected rd_data %02h accepted %0b err %0b ovf %0b flt %0b count %0d",
                       want.rd_data, want.accepted, want.read_error, want.overflow_fault,
                       want.buffer_fault, want.readable_count);
              $display("  actual   rd_data %02h accepted %0b err %0b ovf %0b flt %0b count %0d",
                       got.rd_data, got.accepted, got.read_error, got.overflow_fault,
                       got.buffer_fault, got.readable_count);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        pending_status.push_back(apply_command(cmd, wr_data, rewind_count));
      if (cfg_valid && cfg_ready)
        apply_register(cfg_index, cfg_data);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver stalls at random, independently of whether a result waits.
  always @(negedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Drivers. All of them start and finish just after a falling edge, and all
  // inputs change with nonblocking assignments at falling edges only.
  // --------------------------------------------------------------------------

  // Sends one command item, with a random gap ahead of it. Valid is only
  // lowered for a gap, so back-to-back items keep it high throughout.
  task automatic send_command(cmd_t op, logic [DATA_W-1:0] data,
                              logic [QTY_W-1:0] qty);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= op;
    wr_data      <= data;
    rewind_count <= qty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Lets every outstanding result item arrive, leaving the block idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_status.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random command items. Writes dominate so that the ring fills and
  // overflows; most rewinds stay within one wrap so that the ring keeps
  // working, and a faulted ring is cleared soon so that traffic goes on.
  task automatic send_random(int n);
    int          i;
    int          k;
    cmd_t        op;
    logic [QTY_W-1:0] qty;
    for (i = 0; i < n; i++) begin
      k   = $urandom_range(99);
      qty = QTY_W'($urandom_range(511));
      if ((ovf_flag || fault_flag) && $urandom_range(3) == 0) begin
        op = CMD_CLEAR;
      end else if (k < 42) begin
        op = CMD_WRITE;
      end else if (k < 64) begin
        op = CMD_READ;
      end else if (k < 74) begin
        op = CMD_PEEK;
      end else if (k < 86) begin
        op = CMD_REWIND;
        if ($urandom_range(4) != 0) qty = QTY_W'($urandom_range(ring_size()));
      end else if (k < 89) begin
        op = CMD_CLEAR;
      end else if (k < 92) begin
        op = cmd_t'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      end else begin
        op = CMD_WRITE;
      end
      send_command(op, DATA_W'($urandom_range(255)), qty);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every command on a ring of four slots, which holds three bytes: empty
  // reads, filling to full, overflow and its blocking of writes, draining,
  // rewinds within and beyond one wrap, the buffer fault blocking reads and
  // writes, the unused command codes, and a clear that removes both faults.
  task automatic test_basic_commands();
    int c;
    wait_idle();
    write_reg(CFG_BUFFER_SIZE, 9'd4);
    send_command(CMD_PEEK,   8'h00, 9'd0);
    send_command(CMD_READ,   8'hFF, 9'h1FF);
    send_command(CMD_WRITE,  8'h00, 9'd0);
    send_command(CMD_WRITE,  8'hFF, 9'h1FF);
    send_command(CMD_WRITE,  8'hA5, 9'd0);
    send_command(CMD_WRITE,  8'h5A, 9'd0);   // ring full: overflow fault
    send_command(CMD_WRITE,  8'h11, 9'd0);   // refused while the fault stands
    send_command(CMD_PEEK,   8'h00, 9'd0);
    send_command(CMD_READ,   8'h00, 9'd0);
    send_command(CMD_READ,   8'h00, 9'd0);
    send_command(CMD_REWIND, 8'h00, 9'd1);   // back onto a slot already zeroed
    send_command(CMD_READ,   8'h00, 9'd0);
    send_command(CMD_REWIND, 8'h00, 9'd0);
    send_command(CMD_REWIND, 8'h00, 9'd4);   // exactly one wrap
    send_command(CMD_REWIND, 8'h00, 9'h1FF); // beyond one wrap: buffer fault
    send_command(CMD_READ,   8'h00, 9'd0);
    send_command(CMD_PEEK,   8'h00, 9'd0);
    send_command(CMD_WRITE,  8'h3C, 9'd0);
    send_command(CMD_REWIND, 8'h00, 9'd2);   // still allowed while faulted
    for (c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
      send_command(cmd_t'(c), 8'hFF, 9'h1FF);
    send_command(CMD_CLEAR,  8'h00, 9'd0);
    send_command(CMD_WRITE,  8'h7E, 9'd0);
    send_command(CMD_READ,   8'h00, 9'd0);
  endtask

  // With overflow allowed, a write to a full ring is dropped and no fault is
  // raised; a two-slot ring holds a single byte, so it is full at once.
  task automatic test_overflow_allowed();
    wait_idle();
    write_reg(CFG_BUFFER_SIZE, 9'd2);
    write_reg(CFG_ALLOW_OVERFLOW, {8'hAA, 1'b1});
    send_command(CMD_WRITE, 8'h81, 9'd0);
    send_command(CMD_WRITE, 8'h42, 9'd0);
    send_command(CMD_WRITE, 8'h24, 9'd0);
    send_command(CMD_PEEK,  8'h00, 9'd0);
    send_command(CMD_READ,  8'h00, 9'd0);
    send_command(CMD_READ,  8'h00, 9'd0);
    send_command(CMD_WRITE, 8'hC3, 9'd0);
    send_command(CMD_READ,  8'h00, 9'd0);
    wait_idle();
    write_reg(CFG_ALLOW_OVERFLOW, {8'h55, 1'b0});
  endtask

  // Sizes below two and above the store saturate; each setting gets a short
  // burst of random traffic. A write to a register index that does not exist
  // must change nothing.
  task automatic test_size_saturation();
    logic [CFG_DATA_W-1:0] sizes [4];
    int i;
    sizes = '{9'd0, 9'd1, 9'd257, 9'h1FF};
    for (i = 0; i < 4; i++) begin
      wait_idle();
      write_reg(CFG_BUFFER_SIZE, sizes[i]);
      if (i == 1) write_reg(CFG_SPARE, 9'h1FF);
      send_random(15);
    end
  endtask

  // One phase of random traffic under a given pattern of gaps and stalls.
  task automatic test_random_traffic(int idle, int stall, logic [CFG_DATA_W-1:0] size,
                                     logic allow, int n);
    wait_idle();
    write_reg(CFG_BUFFER_SIZE, size);
    write_reg(CFG_ALLOW_OVERFLOW, {8'($urandom_range(255)), allow});
    idle_pct  = idle;
    stall_pct = stall;
    send_random(n);
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = CMD_WRITE;
    wr_data      = '0;
    rewind_count = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_BUFFER_SIZE;
    cfg_data     = '0;
    fail_count   = 0;
    cycle_count  = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    size_reg     = 9'd256;
    allow_ovf    = 1'b0;
    clear_ring();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // The store is swept clean after reset; nothing is sent until it is done.
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);

    test_basic_commands();
    test_overflow_allowed();
    test_size_saturation();
    test_random_traffic(0,  0,  9'd5,                                1'b0, 190);
    test_random_traffic(75, 0,  CFG_DATA_W'($urandom_range(12, 2)), 1'b1, 190);
    test_random_traffic(0,  75, 9'd256,                              1'b0, 190);
    test_random_traffic(28, 28, CFG_DATA_W'($urandom_range(12, 2)), 1'b0, 190);

    wait_idle();
    repeat (16) @(negedge clk);
    if (fail_count == 0 && pending_status.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
